/* sv/fifo_or_shortest_first_request_queue_core_macros.svh */
// assertion macros used by the checker file
// depends on nothing; expects clk and rst_n in the using scope
`ifndef FIFO_OR_SHORTEST_FIRST_REQUEST_QUEUE_CORE_MACROS_SVH
`define FIFO_OR_SHORTEST_FIRST_REQUEST_QUEUE_CORE_MACROS_SVH

// same-cycle implication
`define FSFQ_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fsfq assertion failed");

// next-cycle implication
`define FSFQ_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fsfq assertion failed");

`endif

/* sv/fsfq_pkg.sv */
// shared types and codes of the request queue
// depends on nothing
package fsfq_pkg;

    localparam int ENTRY_W = 79;

    typedef struct packed {
        logic [15:0] handle;
        logic [31:0] name;
        logic [30:0] size;
    } entry_t;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    localparam logic POLICY_FIFO = 1'b0;

    localparam logic REG_POLICY   = 1'b0;
    localparam logic REG_CAPACITY = 1'b1;

endpackage

/* sv/fsfq_ram.sv */
// generic single-write single-read ram with registered read data
// depends on nothing
module fsfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/fifo_or_shortest_first_request_queue_core.sv */
// Request queue: push and pop items on a valid/ready input channel, one result
// item per input item on a valid/ready output channel. Policy register 0 keeps
// arrival order (circular buffer), 1 serves the smallest file size first
// (binary min-heap in the entry ram). Capacity register limits occupancy.
// A push into a full queue returns status full, a pop from an empty queue
// returns status empty; popped payload is zero on every other result.
// Fifo push writes the ram directly and fifo pop reads it; heap push moves the
// new item up from the last slot, heap pop takes the root, moves the last item
// to the root and moves it down, one level at a time. The single read port of
// the entry ram sets this pace: every heap level needs a read and a compare
// before the next address is known. One item is handled at a time; the next
// is taken once the result is in the output register.
// A stalled receiver holds the result in the output register and the block
// stops at the end of the following item. Reset empties the queue, sets
// fifo policy and capacity 1024; the ram needs no clearing pass. Writing a
// different policy empties the queue.
// depends on fsfq_pkg, fsfq_ram
module fifo_or_shortest_first_request_queue_core #(
    parameter int QUEUE_DEPTH = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [15:0] conn_handle,
    input  logic [31:0] name_ref,
    input  logic [30:0] file_size,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [15:0] out_handle,
    output logic [31:0] out_name_ref,
    output logic [30:0] out_size,
    output logic [10:0] occupancy,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int XW = CW + 2;
    localparam int KW = (CW > 11) ? CW : 11;

    typedef enum logic [3:0] {
        ST_IDLE, ST_FPOP, ST_HUP, ST_HUP_CMP, ST_HPOP0, ST_HPOP1,
        ST_HDN, ST_HDN_L, ST_HDN_R, ST_RESP
    } state_t;

    state_t                 state_reg, state_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [AW-1:0]          head_reg, head_next, tail_reg, tail_next;
    logic                   policy_reg, policy_next;
    logic [10:0]            cap_reg, cap_next;
    fsfq_pkg::entry_t       mov_reg, mov_next, best_reg, best_next;
    logic [AW-1:0]          pos_reg, pos_next, par_reg, par_next;
    logic [AW-1:0]          best_idx_reg, best_idx_next;
    logic                   best_sel_reg, best_sel_next;
    logic [1:0]             res_status_reg, res_status_next;
    fsfq_pkg::entry_t       res_data_reg, res_data_next;
    logic                   out_valid_reg, out_valid_next;
    logic [1:0]             out_status_reg, out_status_next;
    fsfq_pkg::entry_t       out_data_reg, out_data_next;
    logic [10:0]            out_occ_reg, out_occ_next;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr, ram_raddr;
    fsfq_pkg::entry_t       ram_wdata, rd;
    logic [fsfq_pkg::ENTRY_W-1:0] ram_rdata;

    logic [XW-1:0]          pos_x, left_x, right_x, cnt_x;
    logic [KW-1:0]          cap_x, cap_eff, cnt_k;
    logic                   full, cfg_wr, lsel, rsel;
    fsfq_pkg::entry_t       item;

    fsfq_ram #(
        .WIDTH (fsfq_pkg::ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd      = fsfq_pkg::entry_t'(ram_rdata);
    assign pos_x   = XW'(pos_reg);
    assign left_x  = (pos_x << 1) + XW'(1);
    assign right_x = left_x + XW'(1);
    assign cnt_x   = XW'(count_reg);
    assign cap_x   = KW'(cap_reg);
    assign cnt_k   = KW'(count_reg);
    assign cap_eff = (cap_x > KW'(QUEUE_DEPTH)) ? KW'(QUEUE_DEPTH) : cap_x;
    assign full    = cnt_k >= cap_eff;
    assign item    = '{handle: conn_handle, name: name_ref, size: file_size};
    assign cfg_wr  = psel && penable && pwrite;

    assign in_ready     = (state_reg == ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign out_handle   = out_data_reg.handle;
    assign out_name_ref = out_data_reg.name;
    assign out_size     = out_data_reg.size;
    assign occupancy    = out_occ_reg;
    assign pready       = 1'b1;
    assign prdata       = (paddr[2] == fsfq_pkg::REG_CAPACITY) ? {21'b0, cap_reg}
                                                               : {31'b0, policy_reg};

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        policy_next     = policy_reg;
        cap_next        = cap_reg;
        mov_next        = mov_reg;
        best_next       = best_reg;
        pos_next        = pos_reg;
        par_next        = par_reg;
        best_idx_next   = best_idx_reg;
        best_sel_next   = best_sel_reg;
        res_status_next = res_status_reg;
        res_data_next   = res_data_reg;
        out_status_next = out_status_reg;
        out_data_next   = out_data_reg;
        out_occ_next    = out_occ_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        ram_we          = 1'b0;
        ram_waddr       = pos_reg;
        ram_wdata       = mov_reg;
        ram_raddr       = '0;
        lsel            = rd.size < mov_reg.size;
        rsel            = rd.size < best_reg.size;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    res_status_next = fsfq_pkg::STATUS_OK;
                    res_data_next   = '0;
                    state_next      = ST_RESP;
                    if (kind == fsfq_pkg::KIND_PUSH)
                    begin
                        if (full)
                        begin
                            res_status_next = fsfq_pkg::STATUS_FULL;
                        end
                        else if (policy_reg == fsfq_pkg::POLICY_FIFO)
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = tail_reg;
                            ram_wdata  = item;
                            tail_next  = (tail_reg == AW'(QUEUE_DEPTH - 1)) ? '0
                                                                          : tail_reg + AW'(1);
                            count_next = count_reg + CW'(1);
                        end
                        else
                        begin
                            mov_next   = item;
                            pos_next   = AW'(count_reg);
                            count_next = count_reg + CW'(1);
                            state_next = ST_HUP;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = fsfq_pkg::STATUS_EMPTY;
                        end
                        else if (policy_reg == fsfq_pkg::POLICY_FIFO)
                        begin
                            ram_raddr  = head_reg;
                            head_next  = (head_reg == AW'(QUEUE_DEPTH - 1)) ? '0
                                                                          : head_reg + AW'(1);
                            count_next = count_reg - CW'(1);
                            state_next = ST_FPOP;
                        end
                        else
                        begin
                            ram_raddr  = '0;
                            state_next = ST_HPOP0;
                        end
                    end
                end
            end
            ST_FPOP:
            begin
                res_data_next = rd;
                state_next    = ST_RESP;
            end
            ST_HUP:
            begin
                if (pos_reg == '0)
                begin
                    ram_we     = 1'b1;
                    state_next = ST_RESP;
                end
                else
                begin
                    ram_raddr  = (pos_reg - AW'(1)) >> 1;
                    par_next   = (pos_reg - AW'(1)) >> 1;
                    state_next = ST_HUP_CMP;
                end
            end
            ST_HUP_CMP:
            begin
                ram_we = 1'b1;
                if (rd.size > mov_reg.size)
                begin
                    ram_wdata  = rd;
                    pos_next   = par_reg;
                    state_next = ST_HUP;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end
            ST_HPOP0:
            begin
                res_data_next = rd;
                count_next    = count_reg - CW'(1);
                if (count_reg == CW'(1))
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    ram_raddr  = AW'(count_reg - CW'(1));
                    state_next = ST_HPOP1;
                end
            end
            ST_HPOP1:
            begin
                mov_next   = rd;
                pos_next   = '0;
                state_next = ST_HDN;
            end
            ST_HDN:
            begin
                if (left_x >= cnt_x)
                begin
                    ram_we     = 1'b1;
                    state_next = ST_RESP;
                end
                else
                begin
                    ram_raddr  = AW'(left_x);
                    state_next = ST_HDN_L;
                end
            end
            ST_HDN_L:
            begin
                best_next     = lsel ? rd : mov_reg;
                best_idx_next = AW'(left_x);
                best_sel_next = lsel;
                if (right_x < cnt_x)
                begin
                    ram_raddr  = AW'(right_x);
                    state_next = ST_HDN_R;
                end
                else if (lsel)
                begin
                    ram_we     = 1'b1;
                    ram_wdata  = rd;
                    pos_next   = AW'(left_x);
                    state_next = ST_HDN;
                end
                else
                begin
                    ram_we     = 1'b1;
                    state_next = ST_RESP;
                end
            end
            ST_HDN_R:
            begin
                ram_we = 1'b1;
                if (rsel)
                begin
                    ram_wdata  = rd;
                    pos_next   = AW'(right_x);
                    state_next = ST_HDN;
                end
                else if (best_sel_reg)
                begin
                    ram_wdata  = best_reg;
                    pos_next   = best_idx_reg;
                    state_next = ST_HDN;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_data_next   = res_data_reg;
                    out_occ_next    = 11'(count_reg);
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_wr)
        begin
            if (paddr[2] == fsfq_pkg::REG_POLICY)
            begin
                if (pwdata[0] != policy_reg)
                begin
                    count_next = '0;
                    head_next  = '0;
                    tail_next  = '0;
                end
                policy_next = pwdata[0];
            end
            else
            begin
                cap_next = pwdata[10:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            policy_reg     <= fsfq_pkg::POLICY_FIFO;
            cap_reg        <= 11'd1024;
            out_valid_reg  <= 1'b0;
            out_status_reg <= fsfq_pkg::STATUS_OK;
            out_data_reg   <= '0;
            out_occ_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            policy_reg     <= policy_next;
            cap_reg        <= cap_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_data_reg   <= out_data_next;
            out_occ_reg    <= out_occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mov_reg        <= mov_next;
        best_reg       <= best_next;
        pos_reg        <= pos_next;
        par_reg        <= par_next;
        best_idx_reg   <= best_idx_next;
        best_sel_reg   <= best_sel_next;
        res_status_reg <= res_status_next;
        res_data_reg   <= res_data_next;
    end

endmodule

/* sv/fsfq_checker.sv */
// port-level checks of the request queue, bound to the top level
// depends on fsfq_pkg and the macros header
`include "fifo_or_shortest_first_request_queue_core_macros.svh"

module fsfq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic [15:0] out_handle,
    input logic [31:0] out_name_ref,
    input logic [30:0] out_size,
    input logic [10:0] occupancy
);

    `FSFQ_ASSERT_IMP(a_status_code, out_valid, status != 2'd3)
    `FSFQ_ASSERT_IMP(a_zero_payload, out_valid && status != fsfq_pkg::STATUS_OK,
        out_handle == '0 && out_name_ref == '0 && out_size == '0)
    `FSFQ_ASSERT_IMP(a_empty_occ, out_valid && status == fsfq_pkg::STATUS_EMPTY,
        occupancy == '0)
    `FSFQ_ASSERT_NXT(a_hold, out_valid && !out_ready,
        out_valid && $stable(status) && $stable(out_handle) && $stable(occupancy))

endmodule

bind fifo_or_shortest_first_request_queue_core fsfq_checker u_fsfq_checker (.*);

/* tb/tb_fifo_or_shortest_first_request_queue_core.sv */
// testbench of the request queue core: directed table then random push/pop items
// checks each result against a behavioral queue predictor or a directed table value, fifo and min-heap modes
// depends on fsfq_pkg and fifo_or_shortest_first_request_queue_core
module tb_fifo_or_shortest_first_request_queue_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 1024;
    localparam int LIMIT = 600000;
    localparam int SETTLE = 60;

    typedef struct {
        logic [1:0]  status;
        logic [15:0] handle;
        logic [31:0] name;
        logic [30:0] size;
        logic [10:0] occ;
    } result_t;

    typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;

    typedef struct {
        row_kind_t   rk;
        logic        kind;
        logic [15:0] handle;
        logic [31:0] name;
        logic [30:0] size;
        logic        typed;
        logic [1:0]  status;
        logic [10:0] occ;
        logic        reg_idx;
        logic [31:0] value;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        kind = fsfq_pkg::KIND_PUSH;
    logic [15:0] conn_handle = '0;
    logic [31:0] name_ref = '0;
    logic [30:0] file_size = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  status;
    logic [15:0] out_handle;
    logic [31:0] out_name_ref;
    logic [30:0] out_size;
    logic [10:0] occupancy;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    fsfq_pkg::entry_t q_store [DEPTH];
    int          q_head, q_tail, q_count;
    logic        q_policy;
    int          q_cap;
    result_t     expected_results[$];
    int          errors = 0;
    int          cycles = 0;
    int          tx_idle_pct = 0;
    int          rx_stall_pct = 0;
    int          rx_hold = 0;
    int          n_push = 0, n_pop = 0, n_full = 0, n_empty = 0;
    row_t        dir_rows[$];

    fifo_or_shortest_first_request_queue_core uut (.*);

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("%0t timeout", $realtime);
            $display("tb: failure");
            $finish;
        end
    end

    function automatic void swap_slots(int a, int b);
        fsfq_pkg::entry_t t;
        t = q_store[a];
        q_store[a] = q_store[b];
        q_store[b] = t;
    endfunction

    function automatic result_t predict_queue_result(logic k, fsfq_pkg::entry_t e);
        result_t r;
        int cap, up, pos, best, l, rt;
        cap = (q_cap > DEPTH) ? DEPTH : q_cap;
        r = '{fsfq_pkg::STATUS_OK, '0, '0, '0, '0};
        if (k == fsfq_pkg::KIND_PUSH)
        begin
            if (q_count >= cap)
                r.status = fsfq_pkg::STATUS_FULL;
            else if (q_policy == fsfq_pkg::POLICY_FIFO)
            begin
                q_store[q_tail] = e;
                q_tail = (q_tail + 1) % DEPTH;
                q_count++;
            end
            else
            begin
                up = q_count;
                q_store[up] = e;
                q_count++;
                while (up > 0 && q_store[(up - 1) / 2].size > q_store[up].size)
                begin
                    swap_slots((up - 1) / 2, up);
                    up = (up - 1) / 2;
                end
            end
        end
        else if (q_count == 0)
            r.status = fsfq_pkg::STATUS_EMPTY;
        else if (q_policy == fsfq_pkg::POLICY_FIFO)
        begin
            {r.handle, r.name, r.size} = q_store[q_head];
            q_head = (q_head + 1) % DEPTH;
            q_count--;
        end
        else
        begin
            {r.handle, r.name, r.size} = q_store[0];
            q_count--;
            if (q_count != 0)
            begin
                q_store[0] = q_store[q_count];
                pos = 0;
                forever
                begin
                    best = pos;
                    l = 2 * pos + 1;
                    rt = 2 * pos + 2;
                    if (l < q_count && q_store[l].size < q_store[best].size)
                        best = l;
                    if (rt < q_count && q_store[rt].size < q_store[best].size)
                        best = rt;
                    if (best == pos)
                        break;
                    swap_slots(pos, best);
                    pos = best;
                end
            end
        end
        r.occ = q_count[10:0];
        return r;
    endfunction

    task automatic write_reg(logic idx, logic [31:0] val);
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = {idx, 2'b00};
        pwdata = val;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        if (idx == fsfq_pkg::REG_POLICY)
        begin
            if (val[0] != q_policy)
            begin
                q_head = 0;
                q_tail = 0;
                q_count = 0;
                q_policy = val[0];
            end
        end
        else
            q_cap = val[10:0];
    endtask

    // called at a falling edge, returns at a falling edge
    task automatic send_item(logic k, logic [15:0] h, logic [31:0] n, logic [30:0] s,
                             logic typed = 1'b0, logic [1:0] st = fsfq_pkg::STATUS_OK,
                             logic [10:0] oc = '0);
        result_t r;
        logic fire;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        kind = k;
        conn_handle = h;
        name_ref = n;
        file_size = s;
        fire = 1'b0;
        while (!fire)
        begin
            #1;
            fire = in_ready;
            if (fire)
            begin
                r = predict_queue_result(k, {h, n, s});
                if (typed)
                    r = '{st, '0, '0, '0, oc};
                expected_results.push_back(r);
            end
            @(negedge clk);
        end
        in_valid = 1'b0;
    endtask

    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            rx_hold <= rx_hold - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    always @(posedge clk)
    begin
        result_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t unexpected item: status %0d occ %0d", $realtime,
                         status, occupancy);
                errors++;
            end
            else
            begin
                e = expected_results.pop_front();
                if (status == fsfq_pkg::STATUS_FULL) n_full++;
                if (status == fsfq_pkg::STATUS_EMPTY) n_empty++;
                if (status !== e.status)
                begin
                    $display("%0t status exp %0d got %0d", $realtime, e.status, status);
                    errors++;
                end
                if (out_handle !== e.handle)
                begin
                    $display("%0t handle exp %h got %h", $realtime, e.handle, out_handle);
                    errors++;
                end
                if (out_name_ref !== e.name)
                begin
                    $display("%0t name exp %h got %h", $realtime, e.name, out_name_ref);
                    errors++;
                end
                if (out_size !== e.size)
                begin
                    $display("%0t size exp %h got %h", $realtime, e.size, out_size);
                    errors++;
                end
                if (occupancy !== e.occ)
                begin
                    $display("%0t occupancy exp %0d got %0d", $realtime, e.occ, occupancy);
                    errors++;
                end
            end
        end
    end

    function automatic void add_item(logic k, logic [15:0] h, logic [31:0] n, logic [30:0] s,
                                     logic typed = 1'b0,
                                     logic [1:0] st = fsfq_pkg::STATUS_OK,
                                     logic [10:0] oc = '0);
        dir_rows.push_back('{ROW_ITEM, k, h, n, s, typed, st, oc,
                             fsfq_pkg::REG_POLICY, '0});
    endfunction

    function automatic void add_cfg(logic idx, logic [31:0] val);
        dir_rows.push_back('{ROW_CFG, fsfq_pkg::KIND_PUSH, '0, '0, '0, 1'b0,
                             fsfq_pkg::STATUS_OK, '0, idx, val});
    endfunction

    task automatic random_phase(int count, logic pol, int cap, int push_pct);
        logic k;
        logic [30:0] s;
        write_reg(fsfq_pkg::REG_POLICY, {31'd0, pol});
        write_reg(fsfq_pkg::REG_CAPACITY, cap);
        for (int i = 0; i < count; i++)
        begin
            k = ($urandom_range(99) < push_pct) ? fsfq_pkg::KIND_PUSH : fsfq_pkg::KIND_POP;
            s = ($urandom_range(3) == 0) ? 31'($urandom_range(7)) : 31'($urandom);
            if (k == fsfq_pkg::KIND_PUSH) n_push++; else n_pop++;
            send_item(k, 16'($urandom), $urandom, s);
            if (i == count / 2)
            begin
                while (expected_results.size() != 0)
                    @(negedge clk);
            end
        end
    endtask

    initial
    begin
        q_head = 0;
        q_tail = 0;
        q_count = 0;
        q_policy = fsfq_pkg::POLICY_FIFO;
        q_cap = 1024;

        add_item(fsfq_pkg::KIND_POP, '0, '0, '0, 1'b1, fsfq_pkg::STATUS_EMPTY, 11'd0);
        add_item(fsfq_pkg::KIND_PUSH, 16'hFFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b1,
                 fsfq_pkg::STATUS_OK, 11'd1);
        add_item(fsfq_pkg::KIND_PUSH, '0, '0, '0, 1'b1, fsfq_pkg::STATUS_OK, 11'd2);
        add_item(fsfq_pkg::KIND_POP, '0, '0, '0);
        add_item(fsfq_pkg::KIND_POP, '0, '0, '0);
        add_item(fsfq_pkg::KIND_POP, '0, '0, '0, 1'b1, fsfq_pkg::STATUS_EMPTY, 11'd0);
        add_cfg(fsfq_pkg::REG_CAPACITY, 32'd0);
        add_item(fsfq_pkg::KIND_PUSH, 16'h1234, 32'h5555_AAAA, 31'd9, 1'b1,
                 fsfq_pkg::STATUS_FULL, 11'd0);
        add_cfg(fsfq_pkg::REG_CAPACITY, 32'd1);
        add_item(fsfq_pkg::KIND_PUSH, 16'h0001, 32'h1, 31'd1, 1'b1,
                 fsfq_pkg::STATUS_OK, 11'd1);
        add_item(fsfq_pkg::KIND_PUSH, 16'h0002, 32'h2, 31'd2, 1'b1,
                 fsfq_pkg::STATUS_FULL, 11'd1);
        add_cfg(fsfq_pkg::REG_CAPACITY, 32'd2047);
        add_item(fsfq_pkg::KIND_PUSH, 16'h0003, 32'h3, 31'd3);
        add_cfg(fsfq_pkg::REG_POLICY, 32'd1);
        add_item(fsfq_pkg::KIND_POP, '0, '0, '0, 1'b1, fsfq_pkg::STATUS_EMPTY, 11'd0);
        add_item(fsfq_pkg::KIND_PUSH, 16'hA001, 32'hB001, 31'd5);
        add_item(fsfq_pkg::KIND_PUSH, 16'hA002, 32'hB002, 31'd3);
        add_item(fsfq_pkg::KIND_PUSH, 16'hA003, 32'hB003, 31'd3);
        add_item(fsfq_pkg::KIND_PUSH, 16'hA004, 32'hB004, 31'h7FFF_FFFF);
        add_item(fsfq_pkg::KIND_PUSH, 16'hA005, 32'hB005, 31'd0);
        add_item(fsfq_pkg::KIND_PUSH, 16'hA006, 32'hB006, 31'd3);
        add_cfg(fsfq_pkg::REG_CAPACITY, 32'd2);
        add_item(fsfq_pkg::KIND_PUSH, 16'hA007, 32'hB007, 31'd1, 1'b1,
                 fsfq_pkg::STATUS_FULL, 11'd6);
        add_cfg(fsfq_pkg::REG_POLICY, 32'd1);
        for (int i = 0; i < 6; i++)
            add_item(fsfq_pkg::KIND_POP, '0, '0, '0);
        add_cfg(fsfq_pkg::REG_CAPACITY, 32'd1024);
        add_item(fsfq_pkg::KIND_PUSH, 16'hC001, 32'hD001, 31'd4);
        add_cfg(fsfq_pkg::REG_POLICY, 32'd0);
        add_item(fsfq_pkg::KIND_POP, '0, '0, '0, 1'b1, fsfq_pkg::STATUS_EMPTY, 11'd0);

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].rk == ROW_CFG)
                write_reg(dir_rows[i].reg_idx, dir_rows[i].value);
            else
            begin
                if (dir_rows[i].kind == fsfq_pkg::KIND_PUSH) n_push++; else n_pop++;
                send_item(dir_rows[i].kind, dir_rows[i].handle, dir_rows[i].name,
                          dir_rows[i].size, dir_rows[i].typed, dir_rows[i].status,
                          dir_rows[i].occ);
            end
        end

        tx_idle_pct = 20;
        rx_stall_pct = 58;
        random_phase(80, fsfq_pkg::POLICY_FIFO, 1024, 60);
        rx_hold = 400;
        random_phase(80, 1'b1, 1024, 60);
        tx_idle_pct = 58;
        rx_stall_pct = 20;
        random_phase(80, 1'b1, $urandom_range(1, 8), 55);
        random_phase(80, fsfq_pkg::POLICY_FIFO, $urandom_range(1, 8), 55);
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        random_phase(90, 1'b1, 1024, 55);
        random_phase(90, fsfq_pkg::POLICY_FIFO, 2047, 50);

        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        $display("run covered %0d pushes and %0d pops in fifo and shortest-first modes",
                 n_push, n_pop);
        $display("refused pushes %0d, refused pops %0d, in %0d cycles",
                 n_full, n_empty, cycles);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* files.f */
+incdir+sv
sv/fsfq_pkg.sv
sv/fsfq_ram.sv
sv/fifo_or_shortest_first_request_queue_core.sv
sv/fsfq_checker.sv
tb/tb_fifo_or_shortest_first_request_queue_core.sv
